// ===== rtl/core/pcir_pkg.sv =====
// Package for the particle contact impulse resolver.
// Holds item types, word helpers, the step program and the control/status structs.
// No dependencies.
package pcir_pkg;

    localparam int W = 32;
    localparam int F = 16;

    typedef logic signed [W-1:0] t_word;

    localparam t_word ONE_Q  = t_word'(64'd1 << F);
    localparam t_word WMAX   = {1'b0, {(W-1){1'b1}}};
    localparam t_word WMIN   = {1'b1, {(W-1){1'b0}}};

    localparam logic [1:0] REQ_ADD  = 2'd0;
    localparam logic [1:0] REQ_TICK = 2'd1;
    localparam logic [1:0] REQ_COLL = 2'd2;

    localparam logic CFG_INV_MASS    = 1'b0;
    localparam logic CFG_RESTITUTION = 1'b1;

    typedef struct packed {
        logic        [1:0]  req_type;
        logic signed [31:0] vec_x;
        logic signed [31:0] vec_y;
        logic signed [31:0] vec_z;
        logic signed [31:0] scalar_value;
        logic               other_present;
        logic        [30:0] other_inv_mass;
        logic signed [31:0] other_normal_vel;
        logic signed [31:0] other_normal_acc;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
    } t_out_item;

    // Operand and destination codes of the datapath register set.
    typedef enum logic [4:0] {
        S_ZERO, S_ONE,
        S_VEL0, S_VEL1, S_VEL2,
        S_POS0, S_POS1, S_POS2,
        S_FRC0, S_FRC1, S_FRC2,
        S_N0, S_N1, S_N2,
        S_ACC0, S_ACC1, S_ACC2,
        S_SC, S_INVM, S_REST, S_OVEL, S_OACC, S_OIM,
        S_SEP, S_ASEP, S_TOT, S_NS, S_TMP, S_Q, S_RISE
    } t_src;

    typedef enum logic [1:0] {K_ALU, K_DIV, K_END} t_kind;

    typedef enum logic [2:0] {C_ALWAYS, C_VOK, C_ANEG, C_NSNEG, C_POK} t_cond;

    // One step: dst = sat(c +/- mul(a, b)); a divide step takes a / total into Q.
    typedef struct packed {
        t_kind kind;
        t_cond cond;
        t_src  dst;
        t_src  a;
        t_src  b;
        t_src  c;
        logic  sub;
    } t_uop;

    typedef logic [5:0] t_pc;

    localparam t_pc PC_ADD  = 6'd0;
    localparam t_pc PC_TICK = 6'd4;
    localparam t_pc PC_COLL = 6'd14;

    typedef struct packed {
        logic load;
        logic exec;
        logic wb;
        logic div_start;
        logic out_load;
        t_uop op;
    } t_cmd;

    typedef struct packed {
        logic vok;
        logic aneg;
        logic nsneg;
        logic pok;
        logic div_done;
        logic out_free;
    } t_status;

    function automatic t_uop mk(t_kind k, t_cond cd, t_src d, t_src a, t_src b, t_src c,
                                logic s);
        t_uop u;
        u.kind = k; u.cond = cd; u.dst = d; u.a = a; u.b = b; u.c = c; u.sub = s;
        return u;
    endfunction

    function automatic t_uop prog(t_pc pc);
        t_uop u;
        case (pc)
            // add force
            6'd0:  u = mk(K_ALU, C_ALWAYS, S_FRC0, S_N0, S_ONE, S_FRC0, 1'b0);
            6'd1:  u = mk(K_ALU, C_ALWAYS, S_FRC1, S_N1, S_ONE, S_FRC1, 1'b0);
            6'd2:  u = mk(K_ALU, C_ALWAYS, S_FRC2, S_N2, S_ONE, S_FRC2, 1'b0);
            6'd3:  u = mk(K_END, C_ALWAYS, S_ZERO, S_ZERO, S_ZERO, S_ZERO, 1'b0);
            // tick
            6'd4:  u = mk(K_ALU, C_ALWAYS, S_VEL0, S_FRC0, S_INVM, S_VEL0, 1'b0);
            6'd5:  u = mk(K_ALU, C_ALWAYS, S_POS0, S_VEL0, S_SC, S_POS0, 1'b0);
            6'd6:  u = mk(K_ALU, C_ALWAYS, S_FRC0, S_ZERO, S_ONE, S_ZERO, 1'b0);
            6'd7:  u = mk(K_ALU, C_ALWAYS, S_VEL1, S_FRC1, S_INVM, S_VEL1, 1'b0);
            6'd8:  u = mk(K_ALU, C_ALWAYS, S_POS1, S_VEL1, S_SC, S_POS1, 1'b0);
            6'd9:  u = mk(K_ALU, C_ALWAYS, S_FRC1, S_ZERO, S_ONE, S_ZERO, 1'b0);
            6'd10: u = mk(K_ALU, C_ALWAYS, S_VEL2, S_FRC2, S_INVM, S_VEL2, 1'b0);
            6'd11: u = mk(K_ALU, C_ALWAYS, S_POS2, S_VEL2, S_SC, S_POS2, 1'b0);
            6'd12: u = mk(K_ALU, C_ALWAYS, S_FRC2, S_ZERO, S_ONE, S_ZERO, 1'b0);
            6'd13: u = mk(K_END, C_ALWAYS, S_ZERO, S_ZERO, S_ZERO, S_ZERO, 1'b0);
            // collide: separating velocity
            6'd14: u = mk(K_ALU, C_ALWAYS, S_SEP, S_VEL0, S_N0, S_ZERO, 1'b0);
            6'd15: u = mk(K_ALU, C_ALWAYS, S_SEP, S_VEL1, S_N1, S_SEP, 1'b0);
            6'd16: u = mk(K_ALU, C_ALWAYS, S_SEP, S_VEL2, S_N2, S_SEP, 1'b0);
            6'd17: u = mk(K_ALU, C_ALWAYS, S_SEP, S_OVEL, S_ONE, S_SEP, 1'b1);
            // acceleration buildup
            6'd18: u = mk(K_ALU, C_ALWAYS, S_ACC0, S_FRC0, S_INVM, S_ZERO, 1'b0);
            6'd19: u = mk(K_ALU, C_ALWAYS, S_ACC1, S_FRC1, S_INVM, S_ZERO, 1'b0);
            6'd20: u = mk(K_ALU, C_ALWAYS, S_ACC2, S_FRC2, S_INVM, S_ZERO, 1'b0);
            6'd21: u = mk(K_ALU, C_ALWAYS, S_ASEP, S_ACC0, S_N0, S_ZERO, 1'b0);
            6'd22: u = mk(K_ALU, C_ALWAYS, S_ASEP, S_ACC1, S_N1, S_ASEP, 1'b0);
            6'd23: u = mk(K_ALU, C_ALWAYS, S_ASEP, S_ACC2, S_N2, S_ASEP, 1'b0);
            6'd24: u = mk(K_ALU, C_ALWAYS, S_ASEP, S_OACC, S_ONE, S_ASEP, 1'b1);
            6'd25: u = mk(K_ALU, C_ALWAYS, S_TOT, S_OIM, S_ONE, S_INVM, 1'b0);
            // velocity resolution
            6'd26: u = mk(K_ALU, C_VOK, S_NS, S_SEP, S_ONE, S_ZERO, 1'b1);
            6'd27: u = mk(K_ALU, C_VOK, S_NS, S_REST, S_NS, S_ZERO, 1'b0);
            6'd28: u = mk(K_ALU, C_ANEG, S_NS, S_REST, S_ASEP, S_NS, 1'b0);
            6'd29: u = mk(K_ALU, C_NSNEG, S_NS, S_ZERO, S_ONE, S_ZERO, 1'b0);
            6'd30: u = mk(K_ALU, C_VOK, S_TMP, S_SEP, S_ONE, S_NS, 1'b1);
            6'd31: u = mk(K_DIV, C_VOK, S_Q, S_TMP, S_TOT, S_ZERO, 1'b0);
            6'd32: u = mk(K_ALU, C_VOK, S_TMP, S_N0, S_Q, S_ZERO, 1'b0);
            6'd33: u = mk(K_ALU, C_VOK, S_TMP, S_TMP, S_INVM, S_ZERO, 1'b0);
            6'd34: u = mk(K_ALU, C_VOK, S_VEL0, S_TMP, S_ONE, S_VEL0, 1'b0);
            6'd35: u = mk(K_ALU, C_VOK, S_VEL0, S_N0, S_RISE, S_VEL0, 1'b1);
            6'd36: u = mk(K_ALU, C_VOK, S_TMP, S_N1, S_Q, S_ZERO, 1'b0);
            6'd37: u = mk(K_ALU, C_VOK, S_TMP, S_TMP, S_INVM, S_ZERO, 1'b0);
            6'd38: u = mk(K_ALU, C_VOK, S_VEL1, S_TMP, S_ONE, S_VEL1, 1'b0);
            6'd39: u = mk(K_ALU, C_VOK, S_VEL1, S_N1, S_RISE, S_VEL1, 1'b1);
            6'd40: u = mk(K_ALU, C_VOK, S_TMP, S_N2, S_Q, S_ZERO, 1'b0);
            6'd41: u = mk(K_ALU, C_VOK, S_TMP, S_TMP, S_INVM, S_ZERO, 1'b0);
            6'd42: u = mk(K_ALU, C_VOK, S_VEL2, S_TMP, S_ONE, S_VEL2, 1'b0);
            6'd43: u = mk(K_ALU, C_VOK, S_VEL2, S_N2, S_RISE, S_VEL2, 1'b1);
            // penetration resolution
            6'd44: u = mk(K_DIV, C_POK, S_Q, S_SC, S_TOT, S_ZERO, 1'b0);
            6'd45: u = mk(K_ALU, C_POK, S_TMP, S_N0, S_Q, S_ZERO, 1'b0);
            6'd46: u = mk(K_ALU, C_POK, S_TMP, S_TMP, S_INVM, S_ZERO, 1'b0);
            6'd47: u = mk(K_ALU, C_POK, S_POS0, S_TMP, S_ONE, S_POS0, 1'b0);
            6'd48: u = mk(K_ALU, C_POK, S_TMP, S_N1, S_Q, S_ZERO, 1'b0);
            6'd49: u = mk(K_ALU, C_POK, S_TMP, S_TMP, S_INVM, S_ZERO, 1'b0);
            6'd50: u = mk(K_ALU, C_POK, S_POS1, S_TMP, S_ONE, S_POS1, 1'b0);
            6'd51: u = mk(K_ALU, C_POK, S_TMP, S_N2, S_Q, S_ZERO, 1'b0);
            6'd52: u = mk(K_ALU, C_POK, S_TMP, S_TMP, S_INVM, S_ZERO, 1'b0);
            6'd53: u = mk(K_ALU, C_POK, S_POS2, S_TMP, S_ONE, S_POS2, 1'b0);
            default: u = mk(K_END, C_ALWAYS, S_ZERO, S_ZERO, S_ZERO, S_ZERO, 1'b0);
        endcase
        return u;
    endfunction

endpackage

// ===== rtl/core/particle_contact_impulse_resolver_unit.sv =====
// Top level of the particle contact impulse resolver.
// Joins the step controller (pcir_ctrl) and the datapath (pcir_dp); uses pcir_pkg.
//
//   channel  direction  handshake                    payload
//   in       to block   i_in_valid / o_in_ready      i_in_item  (t_in_item)
//   out      from block o_out_valid / i_out_ready    o_out_item (t_out_item)
//   cfg      to block   i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
// One item at a time. Each executed program step passes through issue and write back
// on the shared multiplier and saturating adder; a skipped step only advances the
// program counter, and a divide issues, takes its quotient one bit a cycle, then
// signals done. An unused request runs no steps; every request is accepted in IDLE
// and its result is posted from OUT.
// Reset (synchronous, active low) clears state and loads inv_mass = 1.0.
// The output register frees the controller: a new item is taken while a result
// still waits; only a second result stalls until the first is taken.
module particle_contact_impulse_resolver_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  pcir_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output pcir_pkg::t_out_item o_out_item,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic                i_cfg_index,
    input  logic [30:0]         i_cfg_data
);
    import pcir_pkg::*;

    t_cmd    cmd;
    t_status status;

    // Configuration is always taken and lands at once; write it only while no
    // item is in flight.
    assign o_cfg_ready = 1'b1;

    pcir_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_req_type (i_in_item.req_type),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    pcir_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_item      (i_in_item),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

// ===== rtl/core/pcir_div.sv =====
// Iterative restoring divider: (a << F) / b, b positive, saturated to the word.
// One quotient bit per cycle. Depends on pcir_pkg.
module pcir_div (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  pcir_pkg::t_word i_dividend,
    input  pcir_pkg::t_word i_divisor,
    output logic           o_done,
    output pcir_pkg::t_word o_quot
);
    import pcir_pkg::*;

    localparam int NB = W + F;
    localparam int CW = $clog2(NB);

    logic          r_busy, r_done, r_neg;
    logic [CW-1:0] r_cnt;
    logic [NB-1:0] r_num, r_q;
    logic [W:0]    r_rem;
    logic [W-1:0]  r_den;
    logic [W-1:0]  mag_a;
    logic [W:0]    rem2;
    logic          take;

    assign mag_a = i_dividend[W-1] ? W'(-i_dividend) : W'(i_dividend);
    assign rem2  = {r_rem[W-1:0], r_num[NB-1]};
    assign take  = rem2 >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_num  <= {mag_a, {F{1'b0}}};
                r_rem  <= '0;
                r_q    <= '0;
                r_neg  <= i_dividend[W-1];
                r_den  <= i_divisor;
            end else if (r_busy) begin
                r_rem <= take ? rem2 - {1'b0, r_den} : rem2;
                r_q   <= {r_q[NB-2:0], take};
                r_num <= {r_num[NB-2:0], 1'b0};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(NB - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_comb begin
        if (r_neg) begin
            o_quot = (r_q > NB'(64'd1 << (W - 1))) ? WMIN : -t_word'(r_q[W-1:0]);
        end else begin
            o_quot = (r_q > NB'(WMAX)) ? WMAX : t_word'(r_q[W-1:0]);
        end
    end

    assign o_done = r_done;

endmodule

// ===== rtl/core/pcir_dp.sv =====
// Datapath: particle state, scratch words, shared multiplier and saturating adder,
// configuration registers, output register. Depends on pcir_pkg and pcir_div.
module pcir_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  pcir_pkg::t_cmd       i_cmd,
    output pcir_pkg::t_status    o_status,
    input  pcir_pkg::t_in_item   i_item,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_index,
    input  logic [30:0]          i_cfg_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output pcir_pkg::t_out_item  o_out_item
);
    import pcir_pkg::*;

    t_word r_vel [3];
    t_word r_pos [3];
    t_word r_frc [3];
    t_word r_n   [3];
    t_word r_acc [3];
    t_word r_sc, r_inv, r_rest, r_ovel, r_oacc, r_oim;
    t_word r_sep, r_asep, r_tot, r_ns, r_tmp, r_q;

    logic signed [2*W-1:0] r_prod;
    t_word                 r_c;
    logic                  r_sub;
    t_src                  r_dst;
    logic                  r_out_valid;
    t_out_item             r_out;

    t_word va, vb, vc, quot;
    logic  div_done;
    logic signed [2*W-1:0] bias;
    logic signed [2*W-1:0] scaled;
    t_word                 x;
    logic signed [W+1:0]   sum;
    t_word                 res;

    function automatic t_word pick(t_src s);
        t_word v;
        unique case (s)
            S_ZERO: v = '0;
            S_ONE:  v = ONE_Q;
            S_VEL0: v = r_vel[0];
            S_VEL1: v = r_vel[1];
            S_VEL2: v = r_vel[2];
            S_POS0: v = r_pos[0];
            S_POS1: v = r_pos[1];
            S_POS2: v = r_pos[2];
            S_FRC0: v = r_frc[0];
            S_FRC1: v = r_frc[1];
            S_FRC2: v = r_frc[2];
            S_N0:   v = r_n[0];
            S_N1:   v = r_n[1];
            S_N2:   v = r_n[2];
            S_ACC0: v = r_acc[0];
            S_ACC1: v = r_acc[1];
            S_ACC2: v = r_acc[2];
            S_SC:   v = r_sc;
            S_INVM: v = r_inv;
            S_REST: v = r_rest;
            S_OVEL: v = r_ovel;
            S_OACC: v = r_oacc;
            S_OIM:  v = r_oim;
            S_SEP:  v = r_sep;
            S_ASEP: v = r_asep;
            S_TOT:  v = r_tot;
            S_NS:   v = r_ns;
            S_TMP:  v = r_tmp;
            S_Q:    v = r_q;
            S_RISE: v = r_asep[W-1] ? r_asep : '0;
            default: v = '0;
        endcase
        return v;
    endfunction

    assign va = pick(i_cmd.op.a);
    assign vb = pick(i_cmd.op.b);
    assign vc = pick(i_cmd.op.c);

    pcir_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (va),
        .i_divisor  (vb),
        .o_done     (div_done),
        .o_quot     (quot)
    );

    // Truncate the product toward zero, saturate, then add or subtract.
    always_comb begin
        bias   = r_prod[2*W-1] ? (2*W)'((64'd1 << F) - 1) : '0;
        scaled = (r_prod + bias) >>> F;
        if (scaled > (2*W)'(WMAX)) begin
            x = WMAX;
        end else if (scaled < (2*W)'(WMIN)) begin
            x = WMIN;
        end else begin
            x = scaled[W-1:0];
        end
        sum = r_sub ? ((W+2)'(r_c) - (W+2)'(x)) : ((W+2)'(r_c) + (W+2)'(x));
        if (sum > (W+2)'(WMAX)) begin
            res = WMAX;
        end else if (sum < (W+2)'(WMIN)) begin
            res = WMIN;
        end else begin
            res = sum[W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_vel[i] <= '0;
                r_pos[i] <= '0;
                r_frc[i] <= '0;
            end
            r_inv       <= ONE_Q;
            r_rest      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_INV_MASS:    r_inv  <= t_word'({1'b0, i_cfg_data});
                    CFG_RESTITUTION: r_rest <= t_word'({15'b0, i_cfg_data[16:0]});
                    default: ;
                endcase
            end
            if (i_cmd.load) begin
                r_n[0] <= i_item.vec_x;
                r_n[1] <= i_item.vec_y;
                r_n[2] <= i_item.vec_z;
                r_sc   <= i_item.scalar_value;
                r_ovel <= i_item.other_present ? i_item.other_normal_vel : '0;
                r_oacc <= i_item.other_present ? i_item.other_normal_acc : '0;
                r_oim  <= i_item.other_present ? t_word'({1'b0, i_item.other_inv_mass}) : '0;
            end
            if (i_cmd.exec) begin
                r_prod <= va * vb;
                r_c    <= vc;
                r_sub  <= i_cmd.op.sub;
                r_dst  <= i_cmd.op.dst;
            end
            if (div_done) begin
                r_q <= quot;
            end
            if (i_cmd.wb) begin
                unique case (r_dst)
                    S_VEL0: r_vel[0] <= res;
                    S_VEL1: r_vel[1] <= res;
                    S_VEL2: r_vel[2] <= res;
                    S_POS0: r_pos[0] <= res;
                    S_POS1: r_pos[1] <= res;
                    S_POS2: r_pos[2] <= res;
                    S_FRC0: r_frc[0] <= res;
                    S_FRC1: r_frc[1] <= res;
                    S_FRC2: r_frc[2] <= res;
                    S_ACC0: r_acc[0] <= res;
                    S_ACC1: r_acc[1] <= res;
                    S_ACC2: r_acc[2] <= res;
                    S_SEP:  r_sep    <= res;
                    S_ASEP: r_asep   <= res;
                    S_TOT:  r_tot    <= res;
                    S_NS:   r_ns     <= res;
                    S_TMP:  r_tmp    <= res;
                    default: ;
                endcase
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
                r_out.pos_x <= r_pos[0];
                r_out.pos_y <= r_pos[1];
                r_out.pos_z <= r_pos[2];
                r_out.vel_x <= r_vel[0];
                r_out.vel_y <= r_vel[1];
                r_out.vel_z <= r_vel[2];
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_status.vok      = !(r_sep > 0) && (r_tot > 0);
        o_status.aneg     = o_status.vok && r_asep[W-1];
        o_status.nsneg    = o_status.vok && r_ns[W-1];
        o_status.pok      = (r_sc > 0) && (r_tot > 0);
        o_status.div_done = div_done;
        o_status.out_free = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

// ===== rtl/core/pcir_ctrl.sv =====
// Controller: walks the step program for each item and drives the datapath.
// Depends on pcir_pkg.
module pcir_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [1:0]        i_req_type,
    output logic              o_in_ready,
    input  pcir_pkg::t_status i_status,
    output pcir_pkg::t_cmd    o_cmd
);
    import pcir_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_ISSUE = 5'b00010,
        ST_WB    = 5'b00100,
        ST_DIV   = 5'b01000,
        ST_OUT   = 5'b10000
    } t_state;

    t_state r_state, n_state;
    t_pc    r_pc, n_pc;
    t_uop   op;
    logic   cond_ok;

    assign op = prog(r_pc);

    always_comb begin
        unique case (op.cond)
            C_ALWAYS: cond_ok = 1'b1;
            C_VOK:    cond_ok = i_status.vok;
            C_ANEG:   cond_ok = i_status.aneg;
            C_NSNEG:  cond_ok = i_status.nsneg;
            C_POK:    cond_ok = i_status.pok;
            default:  cond_ok = 1'b0;
        endcase
    end

    always_comb begin
        n_state         = r_state;
        n_pc            = r_pc;
        o_cmd           = '0;
        o_cmd.op        = op;
        o_in_ready      = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_ISSUE;
                    priority case (i_req_type)
                        REQ_ADD:  n_pc = PC_ADD;
                        REQ_TICK: n_pc = PC_TICK;
                        REQ_COLL: n_pc = PC_COLL;
                        default:  n_state = ST_OUT;
                    endcase
                end
            end
            ST_ISSUE: begin
                if (op.kind == K_END) begin
                    n_state = ST_OUT;
                end else if (!cond_ok) begin
                    n_pc = r_pc + 1'b1;
                end else if (op.kind == K_DIV) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = ST_DIV;
                end else begin
                    o_cmd.exec = 1'b1;
                    n_state    = ST_WB;
                end
            end
            ST_WB: begin
                o_cmd.wb = 1'b1;
                n_pc     = r_pc + 1'b1;
                n_state  = ST_ISSUE;
            end
            ST_DIV: begin
                if (i_status.div_done) begin
                    n_pc    = r_pc + 1'b1;
                    n_state = ST_ISSUE;
                end
            end
            ST_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pc    <= '0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
        end
    end

endmodule
